// File: design/rsct_pkg.sv
// Package for the read set conflict tracker: payload structs, codes, sizes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rsct_pkg;
    localparam int READ_ENTRIES_DEF  = 256;
    localparam int ABORT_ENTRIES_DEF = 64;
    localparam logic [8:0] COUNT_MAX = 9'd511;

    typedef enum logic [2:0] {
        K_READ    = 3'd0,
        K_VERSION = 3'd1,
        K_QUERY   = 3'd2,
        K_MARK    = 3'd3,
        K_CLEAR   = 3'd4,
        K_RM_TX   = 3'd5,
        K_RM_READ = 3'd6,
        K_TICK    = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        CFG_ENABLED  = 2'd0,
        CFG_LIFETIME = 2'd1,
        CFG_INTERVAL = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [63:0]        tx_id;
        logic [31:0]        row_id;
        logic [15:0]        col_id;
        logic signed [63:0] row_version;
    } in_item_t;

    typedef struct packed {
        logic       should_abort;
        logic [8:0] newly_aborted;
        logic       read_dropped;
        logic       abort_overflow;
        logic [8:0] expired_count;
    } out_item_t;

    // Sequencer phases.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RSCAN,   // walk the read table
        ST_AFIND,   // search the abort table for one transaction
        ST_ASWEEP,  // walk the abort table for expiry
        ST_DONE
    } state_t;

    function automatic logic [8:0] sat_inc(input logic [8:0] v);
        return (v == COUNT_MAX) ? v : v + 9'd1;
    endfunction
endpackage
`default_nettype wire

// File: design/read_set_conflict_tracker.sv
// Top level of the read set conflict tracker: sequencer, both tables and output register.
// Depends on rsct_pkg.
//
// Usage: an item (kind, transaction, row, column, version) enters on the s_ channel
// with s_valid/s_ready; one result item leaves on the m_ channel with m_valid/m_ready.
// Configuration writes use cfg_we, cfg_index and cfg_data and take effect at once;
// the user must make them only while the block is idle; the block itself does not enforce this.
// One table entry is examined per cycle while a table is walked, each table through
// its own registered read port and compare. Query, mark and clear search the abort
// table and stop at a match; a read registration and a remove read walk the read table;
// a remove transaction walks the read table and then the abort table; a version change
// walks the read table and searches the abort table for each stale reader found. A
// sweeping tick walks both tables; any other tick, or any item while disabled, goes straight to done.
// The block holds one item at a time: s_ready is high only when idle and the previous
// result has been taken, so the next item can enter the cycle after that.
// Reset clears all valid bits and time and presets the countdown; a stalled receiver simply
// holds the result in the output register and the block waits.
`default_nettype none
module read_set_conflict_tracker #(
    parameter int READ_ENTRIES  = rsct_pkg::READ_ENTRIES_DEF,
    parameter int ABORT_ENTRIES = rsct_pkg::ABORT_ENTRIES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rsct_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rsct_pkg::out_item_t    m_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import rsct_pkg::*;
    localparam int RW = $clog2(READ_ENTRIES);
    localparam int AW = $clog2(ABORT_ENTRIES);

    logic        en_reg;
    logic [15:0] life_reg, intv_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b1; life_reg <= 16'd1000; intv_reg <= 16'd100;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENABLED:  en_reg   <= cfg_data[0];
                CFG_LIFETIME: life_reg <= cfg_data;
                CFG_INTERVAL: intv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Tables: fields in memories, valid bits in flip-flops.
    logic [READ_ENTRIES-1:0]  rv_reg;
    logic [ABORT_ENTRIES-1:0] av_reg;
    logic [31:0] r_row [READ_ENTRIES];
    logic [15:0] r_col [READ_ENTRIES];
    logic [63:0] r_tx  [READ_ENTRIES];
    logic [63:0] r_ver [READ_ENTRIES];
    logic [31:0] r_stp [READ_ENTRIES];
    logic [63:0] a_tx  [ABORT_ENTRIES];
    logic [31:0] a_stp [ABORT_ENTRIES];

    state_t state_reg, state_next;
    in_item_t item_reg;
    logic [RW:0] ri_reg, ri_next;
    logic [AW:0] ai_reg, ai_next;
    logic [63:0] cand_reg, cand_next;       // transaction being marked
    logic dup_reg, dup_next, hasfree_reg, hasfree_next;
    logic [RW-1:0] free_reg, free_next;
    logic [AW-1:0] afree_reg, afree_next;
    logic afhas_reg, afhas_next;
    logic [31:0] time_reg;
    logic [15:0] cd_reg;
    out_item_t res_reg, res_next;
    logic mv_reg;

    // Registered read ports, one per table.
    logic [31:0] rd_row, rd_stp, ad_stp;
    logic [15:0] rd_col;
    logic [63:0] rd_tx, rd_ver, ad_tx;
    logic [RW-1:0] raddr;
    logic [AW-1:0] aaddr;
    logic r_we, a_we;
    logic [RW-1:0] r_wa;
    logic [AW-1:0] a_wa;
    logic [63:0] a_wtx;

    assign raddr = ri_next[RW-1:0];
    assign aaddr = ai_next[AW-1:0];
    always_ff @(posedge aclk) begin
        rd_row <= r_row[raddr]; rd_col <= r_col[raddr]; rd_tx <= r_tx[raddr];
        rd_ver <= r_ver[raddr]; rd_stp <= r_stp[raddr];
        ad_tx  <= a_tx[aaddr];  ad_stp <= a_stp[aaddr];
        if (r_we) begin
            r_row[r_wa] <= item_reg.row_id; r_col[r_wa] <= item_reg.col_id;
            r_tx[r_wa] <= item_reg.tx_id; r_ver[r_wa] <= item_reg.row_version;
            r_stp[r_wa] <= time_reg;
        end
        if (a_we) begin
            a_tx[a_wa] <= a_wtx; a_stp[a_wa] <= time_reg;
        end
    end

    logic rlast, alast, rvalid_i, avalid_i, rexp, aexp, rkey;
    logic [RW-1:0] ri;
    logic [AW-1:0] ai;
    assign ri = ri_reg[RW-1:0];
    assign ai = ai_reg[AW-1:0];
    assign rlast = (ri_reg == (RW+1)'(READ_ENTRIES - 1));
    assign alast = (ai_reg == (AW+1)'(ABORT_ENTRIES - 1));
    assign rvalid_i = rv_reg[ri];
    assign avalid_i = av_reg[ai];
    assign rexp = (time_reg - rd_stp) > {16'd0, life_reg};
    assign aexp = (time_reg - ad_stp) > {16'd0, life_reg};
    assign rkey = (rd_row == item_reg.row_id) && (rd_col == item_reg.col_id);

    logic rv_clr, av_clr, av_set;
    logic [AW-1:0] av_idx;

    always_comb begin
        state_next = state_reg; ri_next = ri_reg; ai_next = ai_reg;
        cand_next = cand_reg; dup_next = dup_reg;
        hasfree_next = hasfree_reg; free_next = free_reg;
        afree_next = afree_reg; afhas_next = afhas_reg;
        res_next = res_reg;
        r_we = 1'b0; r_wa = free_reg; a_we = 1'b0; a_wa = afree_reg; a_wtx = cand_reg;
        rv_clr = 1'b0; av_clr = 1'b0; av_set = 1'b0; av_idx = ai;
        s_ready = (state_reg == ST_IDLE) && !mv_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    res_next = '0; ri_next = '0; ai_next = '0;
                    dup_next = 1'b0; hasfree_next = 1'b0;
                    afhas_next = 1'b0; cand_next = s_data.tx_id;
                    if (!en_reg) state_next = ST_DONE;
                    else begin
                        priority case (kind_t'(s_data.kind))
                            K_READ, K_VERSION, K_RM_TX, K_RM_READ: state_next = ST_RSCAN;
                            K_TICK: begin
                                state_next = (cd_reg <= 16'd1) ? ST_RSCAN : ST_DONE;
                            end
                            default: state_next = ST_AFIND;
                        endcase
                    end
                end
            end
            ST_RSCAN: begin
                priority case (kind_t'(item_reg.kind))
                    K_READ: begin
                        if (rvalid_i) begin
                            if (rkey && rd_tx == item_reg.tx_id
                                && rd_ver == item_reg.row_version) dup_next = 1'b1;
                        end else if (!hasfree_reg) begin
                            hasfree_next = 1'b1; free_next = ri;
                        end
                    end
                    K_RM_TX: if (rvalid_i && rd_tx == item_reg.tx_id) rv_clr = 1'b1;
                    K_RM_READ: if (rvalid_i && rkey && rd_tx == item_reg.tx_id) rv_clr = 1'b1;
                    K_TICK: if (rvalid_i && rexp) begin
                        rv_clr = 1'b1;
                        res_next.expired_count = sat_inc(res_reg.expired_count);
                    end
                    default: ;
                endcase
                if (item_reg.kind == K_VERSION && rvalid_i && rkey
                    && $signed(rd_ver) < item_reg.row_version) begin
                    // Stale reader: check the abort table for it, then return here.
                    cand_next = rd_tx; ai_next = '0;
                    afhas_next = 1'b0; state_next = ST_AFIND;
                end else if (rlast) begin
                    if (item_reg.kind == K_READ) begin
                        if (!dup_next) begin
                            if (hasfree_next) begin
                                r_we = 1'b1; r_wa = free_next;
                            end else res_next.read_dropped = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else if (item_reg.kind == K_RM_TX) begin
                        ai_next = '0; state_next = ST_AFIND;
                    end else if (item_reg.kind == K_TICK) begin
                        ai_next = '0; state_next = ST_ASWEEP;
                    end else state_next = ST_DONE;
                end else ri_next = ri_reg + 1'b1;
            end
            ST_AFIND: begin
                // Note free slots on the way for a later insert.
                if (!avalid_i && !afhas_reg) begin
                    afhas_next = 1'b1; afree_next = ai;
                end
                if (avalid_i && ad_tx == cand_reg) begin
                    priority case (kind_t'(item_reg.kind))
                        K_QUERY: res_next.should_abort = 1'b1;
                        K_MARK: begin
                            a_we = 1'b1; a_wa = ai; av_idx = ai; av_set = 1'b1;
                        end
                        K_CLEAR, K_RM_TX: av_clr = 1'b1;
                        default: ;
                    endcase
                    state_next = (item_reg.kind == K_VERSION && !rlast) ? ST_RSCAN : ST_DONE;
                    if (item_reg.kind == K_VERSION) ri_next = ri_reg + 1'b1;
                end else if (alast) begin
                    if (item_reg.kind == K_MARK || item_reg.kind == K_VERSION) begin
                        if (afhas_next) begin
                            a_we = 1'b1; a_wa = afree_next; a_wtx = cand_reg;
                            av_idx = afree_next; av_set = 1'b1;
                            if (item_reg.kind == K_VERSION)
                                res_next.newly_aborted = sat_inc(res_reg.newly_aborted);
                        end else res_next.abort_overflow = 1'b1;
                    end
                    if (item_reg.kind == K_VERSION && !rlast) begin
                        state_next = ST_RSCAN; ri_next = ri_reg + 1'b1;
                    end else state_next = ST_DONE;
                end else ai_next = ai_reg + 1'b1;
            end
            ST_ASWEEP: begin
                if (avalid_i && aexp) begin
                    av_clr = 1'b1;
                    res_next.expired_count = sat_inc(res_reg.expired_count);
                end
                if (alast) state_next = ST_DONE;
                else ai_next = ai_reg + 1'b1;
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; rv_reg <= '0; av_reg <= '0; time_reg <= '0;
            cd_reg <= 16'd100; mv_reg <= 1'b0; ri_reg <= '0; ai_reg <= '0;
        end else begin
            state_reg <= state_next; ri_reg <= ri_next; ai_reg <= ai_next;
            if (rv_clr) rv_reg[ri] <= 1'b0;
            if (r_we) rv_reg[r_wa] <= 1'b1;
            if (av_clr) av_reg[av_idx] <= 1'b0;
            if (av_set) av_reg[av_idx] <= 1'b1;
            if (state_reg == ST_IDLE && s_valid && s_ready && en_reg
                && s_data.kind == K_TICK) begin
                time_reg <= time_reg + 32'd1;
                cd_reg <= (cd_reg <= 16'd1) ? ((intv_reg == 16'd0) ? 16'd1 : intv_reg)
                                            : cd_reg - 16'd1;
            end
            if (state_reg == ST_DONE) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    // The tick increments time before its sweep; the sweep uses the new time.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid && s_ready) item_reg <= s_data;
        cand_reg <= cand_next; dup_reg <= dup_next;
        hasfree_reg <= hasfree_next; free_reg <= free_next;
        afree_reg <= afree_next; afhas_reg <= afhas_next;
        res_reg <= res_next;
    end

    assign m_valid = mv_reg;
    assign m_data  = res_reg;
endmodule
`default_nettype wire

// File: bench/read_set_conflict_tracker_tb.sv
// Testbench for read_set_conflict_tracker: directed and random items, with results
// checked against a behavioral model of both tables. Depends on rsct_pkg and the RTL.
`default_nettype none
module read_set_conflict_tracker_tb;
    import rsct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREAD  = 256;
    localparam int NABORT = 64;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    read_set_conflict_tracker dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model state of the tracker.
    logic        mdl_enabled;
    logic [15:0] mdl_lifetime;
    logic [15:0] mdl_interval;
    logic        rd_valid [NREAD];
    logic [31:0] rd_row [NREAD];
    logic [15:0] rd_col [NREAD];
    logic [63:0] rd_tx [NREAD];
    logic signed [63:0] rd_ver [NREAD];
    logic [31:0] rd_stamp [NREAD];
    logic        ab_valid [NABORT];
    logic [63:0] ab_tx [NABORT];
    logic [31:0] ab_stamp [NABORT];
    logic [31:0] now_ticks;
    logic [15:0] sweep_left;

    in_item_t  pending_items [$];
    out_item_t expected_results [$];
    int errors = 0;
    bit feeding = 1'b0;
    bit drain_hold = 1'b0;
    int long_stall = 0;

    task automatic queue_item(in_item_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic int abort_slot(logic [63:0] tx);
        for (int i = 0; i < NABORT; i++)
            if (ab_valid[i] && ab_tx[i] == tx) return i;
        return -1;
    endfunction

    // 1 new, 0 renewed, -1 no room.
    function automatic int mark_abort(logic [63:0] tx);
        int s;
        s = abort_slot(tx);
        if (s >= 0) begin
            ab_stamp[s] = now_ticks;
            return 0;
        end
        for (int i = 0; i < NABORT; i++)
            if (!ab_valid[i]) begin
                ab_valid[i] = 1'b1;
                ab_tx[i] = tx;
                ab_stamp[i] = now_ticks;
                return 1;
            end
        return -1;
    endfunction

    function automatic logic is_stale(logic [31:0] stamp);
        logic [31:0] age;
        age = now_ticks - stamp;
        return age > {16'd0, mdl_lifetime};
    endfunction

    function automatic out_item_t track_item(in_item_t it);
        out_item_t r;
        int free_slot, s, m;
        bit dup;
        r = '0;
        if (!mdl_enabled) return r;
        case (kind_t'(it.kind))
            K_READ: begin
                free_slot = -1;
                dup = 0;
                for (int i = 0; i < NREAD; i++) begin
                    if (rd_valid[i]) begin
                        if (rd_row[i] == it.row_id && rd_col[i] == it.col_id &&
                            rd_tx[i] == it.tx_id && rd_ver[i] == it.row_version) dup = 1;
                    end else if (free_slot < 0) free_slot = i;
                end
                if (!dup) begin
                    if (free_slot < 0) r.read_dropped = 1'b1;
                    else begin
                        rd_valid[free_slot] = 1'b1;
                        rd_row[free_slot] = it.row_id;
                        rd_col[free_slot] = it.col_id;
                        rd_tx[free_slot] = it.tx_id;
                        rd_ver[free_slot] = it.row_version;
                        rd_stamp[free_slot] = now_ticks;
                    end
                end
            end
            K_VERSION: begin
                for (int i = 0; i < NREAD; i++)
                    if (rd_valid[i] && rd_row[i] == it.row_id && rd_col[i] == it.col_id &&
                        rd_ver[i] < it.row_version && abort_slot(rd_tx[i]) < 0) begin
                        m = mark_abort(rd_tx[i]);
                        if (m > 0) begin
                            if (r.newly_aborted != 9'd511) r.newly_aborted++;
                        end else if (m < 0) r.abort_overflow = 1'b1;
                    end
            end
            K_QUERY: r.should_abort = abort_slot(it.tx_id) >= 0;
            K_MARK: if (mark_abort(it.tx_id) < 0) r.abort_overflow = 1'b1;
            K_CLEAR: begin
                s = abort_slot(it.tx_id);
                if (s >= 0) ab_valid[s] = 1'b0;
            end
            K_RM_TX: begin
                for (int i = 0; i < NREAD; i++)
                    if (rd_valid[i] && rd_tx[i] == it.tx_id) rd_valid[i] = 1'b0;
                s = abort_slot(it.tx_id);
                if (s >= 0) ab_valid[s] = 1'b0;
            end
            K_RM_READ: begin
                for (int i = 0; i < NREAD; i++)
                    if (rd_valid[i] && rd_tx[i] == it.tx_id && rd_row[i] == it.row_id &&
                        rd_col[i] == it.col_id) rd_valid[i] = 1'b0;
            end
            default: begin
                now_ticks = now_ticks + 32'd1;
                if (sweep_left <= 16'd1) begin
                    for (int i = 0; i < NREAD; i++)
                        if (rd_valid[i] && is_stale(rd_stamp[i])) begin
                            rd_valid[i] = 1'b0;
                            if (r.expired_count != 9'd511) r.expired_count++;
                        end
                    for (int i = 0; i < NABORT; i++)
                        if (ab_valid[i] && is_stale(ab_stamp[i])) begin
                            ab_valid[i] = 1'b0;
                            if (r.expired_count != 9'd511) r.expired_count++;
                        end
                    sweep_left = (mdl_interval == 16'd0) ? 16'd1 : mdl_interval;
                end else sweep_left = sweep_left - 16'd1;
            end
        endcase
        return r;
    endfunction

    // Driver: bursts with random gaps, fed from pending_items.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            expected_results.insert(expected_results.size(), track_item(s_data));
        end
        if (!(s_valid && !s_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (feeding && !drain_hold && pending_items.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= pending_items.pop_front();
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(30, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
                end else burst_left <= burst_left - 1;
            end else s_valid <= 1'b0;
        end
    end

    // Receiver: random stall pattern, plus a long hold-off whenever long_stall is set.
    int stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            m_ready <= 1'b0;
        end else if (stall_phase[9]) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(3) != 0);
    end

    // Monitor.
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no item outstanding: %h", m_data);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (e.should_abort !== m_data.should_abort) begin
                    $error("should_abort exp %0d got %0d", e.should_abort, m_data.should_abort);
                    errors++;
                end
                if (e.newly_aborted !== m_data.newly_aborted) begin
                    $error("newly_aborted exp %0d got %0d", e.newly_aborted,
                           m_data.newly_aborted);
                    errors++;
                end
                if (e.read_dropped !== m_data.read_dropped) begin
                    $error("read_dropped exp %0d got %0d", e.read_dropped, m_data.read_dropped);
                    errors++;
                end
                if (e.abort_overflow !== m_data.abort_overflow) begin
                    $error("abort_overflow exp %0d got %0d", e.abort_overflow,
                           m_data.abort_overflow);
                    errors++;
                end
                if (e.expired_count !== m_data.expired_count) begin
                    $error("expired_count exp %0d got %0d", e.expired_count,
                           m_data.expired_count);
                    errors++;
                end
            end
        end
    end

    initial begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic in_item_t make_item(kind_t k, logic [63:0] tx, logic [31:0] row,
                                           logic [15:0] col, logic [63:0] ver);
        in_item_t it;
        it.kind = k;
        it.tx_id = tx;
        it.row_id = row;
        it.col_id = col;
        it.row_version = ver;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Small pools of transactions and cells so that items collide.
    logic [63:0] tx_pool [8];
    logic [31:0] row_pool [4];

    function automatic in_item_t random_item();
        int sel;
        logic [63:0] tx;
        logic [31:0] row;
        logic [15:0] col;
        logic [63:0] ver;
        tx = ($urandom_range(9) == 0) ? rand64() : tx_pool[$urandom_range(7)];
        row = ($urandom_range(9) == 0) ? $urandom() : row_pool[$urandom_range(3)];
        col = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(2));
        ver = ($urandom_range(7) == 0) ? rand64()
                                       : 64'(signed'($urandom_range(12)) - 6);
        sel = $urandom_range(99);
        if (sel < 35) return make_item(K_READ, tx, row, col, ver);
        if (sel < 50) return make_item(K_VERSION, tx, row, col, ver);
        if (sel < 62) return make_item(K_QUERY, tx, row, col, ver);
        if (sel < 68) return make_item(K_MARK, tx, row, col, ver);
        if (sel < 73) return make_item(K_CLEAR, tx, row, col, ver);
        if (sel < 77) return make_item(K_RM_TX, tx, row, col, ver);
        if (sel < 82) return make_item(K_RM_READ, tx, row, col, ver);
        return make_item(K_TICK, tx, row, col, ver);
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLED:  mdl_enabled = val[0];
            CFG_LIFETIME: mdl_lifetime = val;
            default:      mdl_interval = val;
        endcase
    endtask

    // Lets all queued items through and waits for their results plus the block's tail.
    // The condition is checked again at a falling edge, once the driver's updates settle.
    task automatic drain_all();
        feeding = 1'b1;
        forever begin
            wait (pending_items.size() == 0 && !s_valid && expected_results.size() == 0);
            @(negedge aclk);
            if (pending_items.size() == 0 && !s_valid && expected_results.size() == 0)
                break;
        end
        repeat (700) @(posedge aclk);
    endtask

    initial begin
        mdl_enabled = 1'b1;
        mdl_lifetime = 16'd1000;
        mdl_interval = 16'd100;
        now_ticks = '0;
        sweep_left = 16'd100;
        for (int i = 0; i < NREAD; i++) rd_valid[i] = 1'b0;
        for (int i = 0; i < NABORT; i++) ab_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) tx_pool[i] = rand64();
        tx_pool[0] = '0;
        tx_pool[1] = '1;
        for (int i = 0; i < 4; i++) row_pool[i] = $urandom();
        row_pool[0] = '0;
        row_pool[1] = '1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes, duplicates, stale readers, marks and removal.
        queue_item(make_item(K_READ, '0, '0, '0, 64'h8000_0000_0000_0000));
        queue_item(make_item(K_READ, '0, '0, '0, 64'h8000_0000_0000_0000));
        queue_item(make_item(K_READ, '1, '1, '1, 64'h7FFF_FFFF_FFFF_FFFE));
        queue_item(make_item(K_READ, 64'd5, '0, '0, 64'd3));
        queue_item(make_item(K_READ, 64'd5, '0, '0, 64'd1));
        queue_item(make_item(K_VERSION, '0, '0, '0, 64'd4));
        queue_item(make_item(K_VERSION, '0, '0, '0, 64'd9));
        queue_item(make_item(K_VERSION, '0, '1, '1, 64'h7FFF_FFFF_FFFF_FFFF));
        queue_item(make_item(K_QUERY, 64'd5, '0, '0, '0));
        queue_item(make_item(K_QUERY, 64'd6, '0, '0, '0));
        queue_item(make_item(K_MARK, 64'd5, '0, '0, '0));
        queue_item(make_item(K_MARK, 64'd6, '0, '0, '0));
        queue_item(make_item(K_CLEAR, 64'd6, '0, '0, '0));
        queue_item(make_item(K_RM_READ, '1, '1, '1, '0));
        queue_item(make_item(K_RM_TX, 64'd5, '0, '0, '0));
        queue_item(make_item(K_QUERY, 64'd5, '0, '0, '0));
        queue_item(make_item(K_TICK, '1, '1, '1, '1));
        drain_all();

        // Fill the read table past capacity, then overflow the abort table.
        for (int i = 0; i < 260; i++)
            queue_item(make_item(K_READ, 64'(i), 32'd77, 16'd7, '0));
        queue_item(make_item(K_VERSION, '0, 32'd77, 16'd7, 64'd1));
        for (int i = 0; i < 4; i++)
            queue_item(make_item(K_MARK, 64'(1000 + i), '0, '0, '0));
        for (int i = 0; i < 260; i++)
            queue_item(make_item(K_RM_TX, 64'(i), '0, '0, '0));
        drain_all();

        // Short lifetime and interval so sweeps expire things.
        write_reg(CFG_LIFETIME, 16'd0);
        write_reg(CFG_INTERVAL, 16'd1);
        for (int i = 0; i < 30; i++) queue_item(random_item());
        for (int i = 0; i < 10; i++)
            queue_item(make_item(K_TICK, '0, '0, '0, '0));
        drain_all();

        // Long receiver hold-off while the sender keeps offering.
        for (int i = 0; i < 40; i++) queue_item(random_item());
        long_stall = 3000;
        feeding = 1'b1;
        drain_all();

        // Disabled phase.
        write_reg(CFG_ENABLED, 16'd0);
        for (int i = 0; i < 40; i++) queue_item(random_item());
        drain_all();
        write_reg(CFG_ENABLED, 16'd1);

        // Random phases over several settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_LIFETIME, 16'd3);
                    write_reg(CFG_INTERVAL, 16'd2);
                end
                1: begin
                    write_reg(CFG_LIFETIME, 16'hFFFF);
                    write_reg(CFG_INTERVAL, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_LIFETIME, 16'd1);
                    write_reg(CFG_INTERVAL, 16'd0);
                end
                default: begin
                    write_reg(CFG_LIFETIME, 16'($urandom_range(20, 2)));
                    write_reg(CFG_INTERVAL, 16'($urandom_range(5, 1)));
                end
            endcase
            for (int i = 0; i < 180; i++) queue_item(random_item());
            // Hold the sender mid-phase until every result is back.
            feeding = 1'b1;
            wait (pending_items.size() < 120);
            drain_hold = 1'b1;
            @(negedge aclk);
            wait (!s_valid && expected_results.size() == 0);
            drain_hold = 1'b0;
            drain_all();
        end

        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
